// ===== hw/rtl/bbpa_pkg.sv =====
package bbpa_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int WORD_BITS    = 32;
    localparam int MAP_WORDS    = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int HEADER_BYTES = 0;

    localparam int ADDR_W   = 32;
    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int WSEL_W   = $clog2(MAP_WORDS);
    localparam int BSEL_W   = $clog2(WORD_BITS);
    localparam int BSIZE_W  = 16;
    localparam int STRIDE_W = BSIZE_W + 1;
    localparam int ITER_W   = $clog2(ADDR_W + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = '0;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST  = 16'd16;
    localparam logic [CNT_W-1:0]   BLOCK_COUNT_RST = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic div;
    } t_mdv_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdv_sts;

    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] idx;
    } t_map_wr;

    function automatic logic [BSEL_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BSEL_W-1:0] pos;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                pos = BSEL_W'(k);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/bbpa_if.sv =====
interface bbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [bbpa_pkg::ADDR_W-1:0]   address;

    modport source (output valid, req_type, address, input ready);
    modport sink   (input valid, req_type, address, output ready);
endinterface

interface bbpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [bbpa_pkg::ADDR_W-1:0]   block_address;
    logic [bbpa_pkg::IDX_W-1:0]    block_index;
    logic [bbpa_pkg::CNT_W-1:0]    used_count;
    logic [bbpa_pkg::ADDR_W-1:0]   miss_count;

    modport source (output valid, ok, block_address, block_index, used_count, miss_count,
                    input ready);
    modport sink   (input valid, ok, block_address, block_index, used_count, miss_count,
                    output ready);
endinterface

interface bbpa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bbpa_pkg::CFG_IDX_W-1:0]  index;
    logic [bbpa_pkg::ADDR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bbpa_muldiv.sv =====
module bbpa_muldiv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bbpa_pkg::t_mdv_cmd              i_cmd,
    input  logic [bbpa_pkg::ADDR_W-1:0]     i_a,
    input  logic [bbpa_pkg::STRIDE_W-1:0]   i_b,
    output bbpa_pkg::t_mdv_sts              o_sts,
    output logic [bbpa_pkg::ADDR_W-1:0]     o_result
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic                            r_div, n_div;
    logic [bbpa_pkg::ITER_W-1:0]     r_cnt, n_cnt;
    logic [bbpa_pkg::ADDR_W-1:0]     r_acc, n_acc;
    logic [bbpa_pkg::ADDR_W-1:0]     r_a, n_a;
    logic [bbpa_pkg::STRIDE_W-1:0]   r_b, n_b;
    logic [bbpa_pkg::STRIDE_W-1:0]   r_rem, n_rem;
    logic [bbpa_pkg::STRIDE_W:0]     trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        trial  = {r_rem, r_a[bbpa_pkg::ADDR_W-1]};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_div  = i_cmd.div;
            n_cnt  = i_cmd.div ? bbpa_pkg::ITER_W'(bbpa_pkg::ADDR_W)
                               : bbpa_pkg::ITER_W'(bbpa_pkg::STRIDE_W);
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_rem  = '0;
        end else if (r_busy) begin
            if (r_div) begin
                if (trial >= {1'b0, r_b}) begin
                    n_rem = bbpa_pkg::STRIDE_W'(trial - {1'b0, r_b});
                    n_acc = {r_acc[bbpa_pkg::ADDR_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[bbpa_pkg::STRIDE_W-1:0];
                    n_acc = {r_acc[bbpa_pkg::ADDR_W-2:0], 1'b0};
                end
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_b = r_b >> 1;
            end
            n_a   = r_a << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == bbpa_pkg::ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_acc;

endmodule

// ===== hw/rtl/bbpa_bitmap.sv =====
module bbpa_bitmap (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bbpa_pkg::WSEL_W-1:0]       i_rd_word,
    output logic [bbpa_pkg::WORD_BITS-1:0]    o_rd_data,
    input  bbpa_pkg::t_map_wr                 i_wr
);

    logic [bbpa_pkg::WORD_BITS-1:0] r_map [bbpa_pkg::MAP_WORDS];
    logic [bbpa_pkg::WSEL_W-1:0]    wr_word;
    logic [bbpa_pkg::BSEL_W-1:0]    wr_bit;

    assign wr_word   = i_wr.idx[bbpa_pkg::IDX_W-1:bbpa_pkg::BSEL_W];
    assign wr_bit    = i_wr.idx[bbpa_pkg::BSEL_W-1:0];
    assign o_rd_data = r_map[i_rd_word];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < bbpa_pkg::MAP_WORDS; w++) begin
                r_map[w] <= '0;
            end
        end else if (i_wr.en) begin
            r_map[wr_word][wr_bit] <= i_wr.set;
        end
    end

endmodule

// ===== hw/rtl/bitmap_block_pool_allocator.sv =====
// Fixed-size block pool allocator with a used/free bitmap.
// Channels: i_req takes one request transaction (req_type, address), o_rsp
// returns exactly one response transaction per request, i_cfg writes the
// registers pool_base (0), block_size (1) and block_count (2); i_cfg is
// always ready and must be written only while the block is idle.
// One request at a time: i_req is ready only when no request is in work
// and no response is waiting.
// Work per request type, from acceptance to o_rsp valid:
//   allocate : scans k bitmap words (1 to 32), then stride times index by shift-add
//   free     : iterative restoring divide, one quotient bit a cycle
//   query    : stride times count-1 by shift-add, one bit a cycle
// The multiply/divide unit is shared by all three; the bitmap scan reads one word a
// cycle, and an allocate that misses skips the multiply.
// o_rsp holds its payload while the receiver stalls; no new request is taken.
// Synchronous reset (i_rst_n low) frees every block, clears both counters
// and returns the registers to base 0, size 16, count 1024.
module bitmap_block_pool_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bbpa_req_if.sink    i_req,
    bbpa_rsp_if.source  o_rsp,
    bbpa_cfg_if.sink    i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                            r_state, n_state;
    logic [1:0]                        r_req, n_req;
    logic [bbpa_pkg::ADDR_W-1:0]       r_addr, n_addr;
    logic [bbpa_pkg::WSEL_W-1:0]       r_word, n_word;
    logic [bbpa_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic [bbpa_pkg::ADDR_W-1:0]       r_pool_base;
    logic [bbpa_pkg::BSIZE_W-1:0]      r_block_size;
    logic [bbpa_pkg::CNT_W-1:0]        r_block_count;
    logic [bbpa_pkg::CNT_W-1:0]        r_used, n_used;
    logic [bbpa_pkg::ADDR_W-1:0]       r_miss, n_miss;
    logic                              r_ok, n_ok;
    logic [bbpa_pkg::ADDR_W-1:0]       r_baddr, n_baddr;
    logic [bbpa_pkg::IDX_W-1:0]        r_bidx, n_bidx;

    logic [bbpa_pkg::CNT_W-1:0]        n_blocks;
    logic [bbpa_pkg::STRIDE_W-1:0]     stride;
    logic [bbpa_pkg::CNT_W-1:0]        word_base;
    logic [bbpa_pkg::CNT_W-1:0]        remain;
    logic [bbpa_pkg::WORD_BITS-1:0]    valid_mask;
    logic [bbpa_pkg::WORD_BITS-1:0]    free_bits;
    logic [bbpa_pkg::WORD_BITS-1:0]    map_word;
    logic                              last_word;
    logic [bbpa_pkg::ADDR_W-1:0]       offset;
    logic [bbpa_pkg::ADDR_W-1:0]       top;
    logic [bbpa_pkg::ADDR_W-1:0]       q_addr;

    bbpa_pkg::t_mdv_cmd                mdv_cmd;
    bbpa_pkg::t_mdv_sts                mdv_sts;
    logic [bbpa_pkg::ADDR_W-1:0]       mdv_a;
    logic [bbpa_pkg::STRIDE_W-1:0]     mdv_b;
    logic [bbpa_pkg::ADDR_W-1:0]       mdv_res;
    bbpa_pkg::t_map_wr                 map_wr;

    bbpa_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mdv_cmd),
        .i_a      (mdv_a),
        .i_b      (mdv_b),
        .o_sts    (mdv_sts),
        .o_result (mdv_res)
    );

    bbpa_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_word (r_word),
        .o_rd_data (map_word),
        .i_wr      (map_wr)
    );

    assign n_blocks = (r_block_count > bbpa_pkg::CNT_W'(bbpa_pkg::MAX_BLOCKS))
                    ? bbpa_pkg::CNT_W'(bbpa_pkg::MAX_BLOCKS) : r_block_count;
    assign stride   = {1'b0, r_block_size} + bbpa_pkg::STRIDE_W'(bbpa_pkg::HEADER_BYTES);

    assign word_base  = {1'b0, r_word, {bbpa_pkg::BSEL_W{1'b0}}};
    assign remain     = n_blocks - word_base;
    assign valid_mask = (remain >= bbpa_pkg::CNT_W'(bbpa_pkg::WORD_BITS)) ? '1
                      : ((bbpa_pkg::WORD_BITS'(1) << remain[bbpa_pkg::BSEL_W-1:0])
                         - bbpa_pkg::WORD_BITS'(1));
    assign free_bits  = ~map_word & valid_mask;
    assign last_word  = (r_word == bbpa_pkg::WSEL_W'(bbpa_pkg::MAP_WORDS - 1))
                     || ((word_base + bbpa_pkg::CNT_W'(bbpa_pkg::WORD_BITS)) >= n_blocks);

    assign offset = i_req.address - r_pool_base - bbpa_pkg::ADDR_W'(bbpa_pkg::HEADER_BYTES);
    assign top    = r_pool_base + mdv_res;
    assign q_addr = r_addr - bbpa_pkg::ADDR_W'(bbpa_pkg::HEADER_BYTES);

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_addr  = r_addr;
        n_word  = r_word;
        n_idx   = r_idx;
        n_used  = r_used;
        n_miss  = r_miss;
        n_ok    = r_ok;
        n_baddr = r_baddr;
        n_bidx  = r_bidx;
        mdv_cmd = '0;
        mdv_a   = '0;
        mdv_b   = '0;
        map_wr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.req_type;
                    n_addr  = i_req.address;
                    n_word  = '0;
                    n_ok    = 1'b0;
                    n_baddr = '0;
                    n_bidx  = '0;
                    n_state = S_OUT;
                    case (i_req.req_type)
                        bbpa_pkg::REQ_ALLOC: begin
                            if (n_blocks != '0) begin
                                n_state = S_SCAN;
                            end else begin
                                n_miss = r_miss + 1'b1;
                            end
                        end
                        bbpa_pkg::REQ_FREE: begin
                            if (i_req.address >= r_pool_base && stride != '0
                                && n_blocks != '0) begin
                                mdv_cmd.start = 1'b1;
                                mdv_cmd.div   = 1'b1;
                                mdv_a         = offset;
                                mdv_b         = stride;
                                n_state       = S_DIV;
                            end
                        end
                        bbpa_pkg::REQ_QUERY: begin
                            if (n_blocks != '0) begin
                                mdv_cmd.start = 1'b1;
                                mdv_a         = bbpa_pkg::ADDR_W'(stride);
                                mdv_b         = bbpa_pkg::STRIDE_W'(n_blocks - 1'b1);
                                n_state       = S_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (free_bits != '0) begin
                    n_idx         = {r_word, bbpa_pkg::lowest_set(free_bits)};
                    map_wr.en     = 1'b1;
                    map_wr.set    = 1'b1;
                    map_wr.idx    = n_idx;
                    n_used        = r_used + 1'b1;
                    mdv_cmd.start = 1'b1;
                    mdv_a         = bbpa_pkg::ADDR_W'(stride);
                    mdv_b         = bbpa_pkg::STRIDE_W'(n_idx);
                    n_state       = S_MUL;
                end else if (last_word) begin
                    n_miss  = r_miss + 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_MUL: begin
                if (mdv_sts.done) begin
                    n_state = S_OUT;
                    if (r_req == bbpa_pkg::REQ_ALLOC) begin
                        n_ok    = 1'b1;
                        n_baddr = r_pool_base + mdv_res
                                + bbpa_pkg::ADDR_W'(bbpa_pkg::HEADER_BYTES);
                        n_bidx  = r_idx;
                    end else begin
                        n_ok = (q_addr >= r_pool_base) && (q_addr <= top);
                    end
                end
            end
            S_DIV: begin
                if (mdv_sts.done) begin
                    n_state = S_OUT;
                    if (mdv_res < bbpa_pkg::ADDR_W'(n_blocks)) begin
                        n_ok       = 1'b1;
                        n_bidx     = mdv_res[bbpa_pkg::IDX_W-1:0];
                        map_wr.en  = 1'b1;
                        map_wr.idx = mdv_res[bbpa_pkg::IDX_W-1:0];
                        if (r_used != '0) begin
                            n_used = r_used - 1'b1;
                        end
                    end
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_used        <= '0;
            r_miss        <= '0;
            r_pool_base   <= bbpa_pkg::POOL_BASE_RST;
            r_block_size  <= bbpa_pkg::BLOCK_SIZE_RST;
            r_block_count <= bbpa_pkg::BLOCK_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_miss  <= n_miss;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    bbpa_pkg::CFG_POOL_BASE:   r_pool_base   <= i_cfg.data;
                    bbpa_pkg::CFG_BLOCK_SIZE:
                        r_block_size  <= i_cfg.data[bbpa_pkg::BSIZE_W-1:0];
                    bbpa_pkg::CFG_BLOCK_COUNT:
                        r_block_count <= i_cfg.data[bbpa_pkg::CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_req   <= n_req;
        r_addr  <= n_addr;
        r_word  <= n_word;
        r_idx   <= n_idx;
        r_ok    <= n_ok;
        r_baddr <= n_baddr;
        r_bidx  <= n_bidx;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.ok            = r_ok;
    assign o_rsp.block_address = r_baddr;
    assign o_rsp.block_index   = r_bidx;
    assign o_rsp.used_count    = r_used;
    assign o_rsp.miss_count    = r_miss;

endmodule

// ===== test/bitmap_block_pool_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_block_pool_allocator_tb;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int QUIET_TAIL = 60;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_WRITE,
        OP_SETTLE
    } t_op_kind;

    typedef struct {
        t_op_kind           kind;
        logic [1:0]         req_type;
        logic [31:0]        address;
        bbpa_pkg::t_cfg_idx reg_idx;
        logic [31:0]        data;
    } t_op;

    typedef struct {
        logic        ok;
        logic [31:0] block_address;
        logic [9:0]  block_index;
        logic [10:0] used_count;
        logic [31:0] miss_count;
    } t_pool_rsp;

    logic i_clk;
    logic i_rst_n;

    bbpa_req_if req_ch ();
    bbpa_rsp_if rsp_ch ();
    bbpa_cfg_if cfg_ch ();

    bitmap_block_pool_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    t_op         pending_ops[$];
    t_pool_rsp   expected_rsps[$];

    logic [31:0]   pool_base_m;
    logic [15:0]   block_size_m;
    logic [10:0]   block_count_m;
    logic [1023:0] used_map_m;
    logic [10:0]   in_use_m;
    logic [31:0]   misses_m;

    int errors;
    int n_alloc_ok, n_alloc_miss, n_free_ok, n_free_bad, n_query_in, n_query_out, n_other;
    int n_writes, n_checked;
    int send_gap, recv_stall, quiet_cycles;

    // generator view of the configuration
    logic [31:0] gen_base;
    int          gen_size, gen_count;

    always #6 i_clk = ~i_clk;

    function automatic t_pool_rsp predict_pool(input logic [1:0] rt, input logic [31:0] a);
        t_pool_rsp   r;
        int          n;
        int          idx;
        bit          found;
        logic [31:0] stride, q, top;
        r = '{default: '0};
        n = (block_count_m > 11'd1024) ? 1024 : int'(block_count_m);
        stride = 32'(block_size_m);
        found = 1'b0;
        idx = 0;
        case (rt)
            bbpa_pkg::REQ_ALLOC: begin
                for (int i = 0; i < n; i++) begin
                    if (!found && !used_map_m[i]) begin
                        found = 1'b1;
                        idx = i;
                    end
                end
                if (found) begin
                    used_map_m[idx] = 1'b1;
                    in_use_m = in_use_m + 11'd1;
                    r.block_address = pool_base_m + 32'(idx) * stride;
                    r.block_index = 10'(idx);
                    r.ok = 1'b1;
                    n_alloc_ok++;
                end else begin
                    misses_m = misses_m + 32'd1;
                    n_alloc_miss++;
                end
            end
            bbpa_pkg::REQ_FREE: begin
                if (a >= pool_base_m && stride != 0 && n != 0) begin
                    q = (a - pool_base_m) / stride;
                    if (q < 32'(n)) begin
                        if (in_use_m > 0) in_use_m = in_use_m - 11'd1;
                        used_map_m[q[9:0]] = 1'b0;
                        r.block_index = q[9:0];
                        r.ok = 1'b1;
                    end
                end
                if (r.ok) n_free_ok++;
                else n_free_bad++;
            end
            bbpa_pkg::REQ_QUERY: begin
                if (n != 0) begin
                    top = pool_base_m + stride * 32'(n - 1);
                    r.ok = (a >= pool_base_m) && (a <= top);
                end
                if (r.ok) n_query_in++;
                else n_query_out++;
            end
            default: n_other++;
        endcase
        r.used_count = in_use_m;
        r.miss_count = misses_m;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic nv, ncv;
        t_op  op;
        nv = 1'b0;
        ncv = 1'b0;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            cfg_ch.valid <= 1'b0;
            send_gap = 0;
            quiet_cycles = 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(predict_pool(req_ch.req_type, req_ch.address));
            if (cfg_ch.valid && cfg_ch.ready) begin
                n_writes++;
                case (cfg_ch.index)
                    bbpa_pkg::CFG_POOL_BASE:   pool_base_m = cfg_ch.data;
                    bbpa_pkg::CFG_BLOCK_SIZE:  block_size_m = cfg_ch.data[15:0];
                    bbpa_pkg::CFG_BLOCK_COUNT: block_count_m = cfg_ch.data[10:0];
                    default: ;
                endcase
            end
            if (expected_rsps.size() == 0 && !req_ch.valid) quiet_cycles++;
            else quiet_cycles = 0;

            if (req_ch.valid && !req_ch.ready) begin
                nv = 1'b1;
            end else if (cfg_ch.valid && !cfg_ch.ready) begin
                ncv = 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops[0];
                if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(1, 18);
                end else if (op.kind == OP_REQUEST) begin
                    nv = 1'b1;
                    req_ch.req_type <= op.req_type;
                    req_ch.address <= op.address;
                    void'(pending_ops.pop_front());
                end else if (quiet_cycles >= 4) begin
                    if (op.kind == OP_WRITE) begin
                        ncv = 1'b1;
                        cfg_ch.index <= op.reg_idx;
                        cfg_ch.data <= op.data;
                    end
                    void'(pending_ops.pop_front());
                end
            end
            req_ch.valid <= nv;
            cfg_ch.valid <= ncv;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pool_rsp e;
        logic      nr;
        nr = 1'b1;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("response with nothing outstanding");
                    errors++;
                end else begin
                    e = expected_rsps.pop_front();
                    n_checked++;
                    if (rsp_ch.ok !== e.ok) begin
                        $error("ok: expected %0h actual %0h", e.ok, rsp_ch.ok);
                        errors++;
                    end
                    if (rsp_ch.block_address !== e.block_address) begin
                        $error("block_address: expected %0h actual %0h",
                               e.block_address, rsp_ch.block_address);
                        errors++;
                    end
                    if (rsp_ch.block_index !== e.block_index) begin
                        $error("block_index: expected %0d actual %0d",
                               e.block_index, rsp_ch.block_index);
                        errors++;
                    end
                    if (rsp_ch.used_count !== e.used_count) begin
                        $error("used_count: expected %0d actual %0d",
                               e.used_count, rsp_ch.used_count);
                        errors++;
                    end
                    if (rsp_ch.miss_count !== e.miss_count) begin
                        $error("miss_count: expected %0d actual %0d",
                               e.miss_count, rsp_ch.miss_count);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                nr = 1'b0;
            end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(0, 17);
                nr = 1'b0;
            end
            rsp_ch.ready <= nr;
        end
    end

    task automatic add_req(input logic [1:0] rt, input logic [31:0] a);
        t_op op;
        op = '{kind: OP_REQUEST, req_type: rt, address: a,
               reg_idx: bbpa_pkg::CFG_POOL_BASE, data: '0};
        pending_ops.push_back(op);
    endtask

    task automatic add_write(input bbpa_pkg::t_cfg_idx ri, input logic [31:0] v);
        t_op op;
        op = '{kind: OP_WRITE, req_type: bbpa_pkg::REQ_ALLOC, address: '0, reg_idx: ri,
               data: v};
        pending_ops.push_back(op);
        case (ri)
            bbpa_pkg::CFG_POOL_BASE:   gen_base = v;
            bbpa_pkg::CFG_BLOCK_SIZE:  gen_size = int'(v[15:0]);
            bbpa_pkg::CFG_BLOCK_COUNT: gen_count = int'(v[10:0]);
            default: ;
        endcase
    endtask

    task automatic add_settle();
        t_op op;
        op = '{kind: OP_SETTLE, req_type: bbpa_pkg::REQ_ALLOC, address: '0,
               reg_idx: bbpa_pkg::CFG_POOL_BASE, data: '0};
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] block_addr_at(input int k);
        return gen_base + 32'(k) * 32'(gen_size);
    endfunction

    initial begin
        int          roll, k, lim;
        logic [31:0] a;
        i_clk = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = bbpa_pkg::REQ_ALLOC;
        req_ch.address = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bbpa_pkg::CFG_POOL_BASE;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        n_alloc_ok = 0; n_alloc_miss = 0; n_free_ok = 0; n_free_bad = 0;
        n_query_in = 0; n_query_out = 0; n_other = 0; n_writes = 0; n_checked = 0;
        pool_base_m = bbpa_pkg::POOL_BASE_RST;
        block_size_m = bbpa_pkg::BLOCK_SIZE_RST;
        block_count_m = bbpa_pkg::BLOCK_COUNT_RST;
        used_map_m = '0;
        in_use_m = '0;
        misses_m = '0;
        gen_base = 32'd0; gen_size = 16; gen_count = 1024;

        // reset values
        add_req(bbpa_pkg::REQ_ALLOC, 32'hFFFF_FFFF);
        add_req(bbpa_pkg::REQ_ALLOC, 32'd0);
        add_req(bbpa_pkg::REQ_ALLOC, 32'd0);
        add_req(bbpa_pkg::REQ_QUERY, 32'd0);
        add_req(bbpa_pkg::REQ_QUERY, 32'd16 * 32'd1023);
        add_req(bbpa_pkg::REQ_QUERY, 32'd16 * 32'd1023 + 32'd1);
        add_req(bbpa_pkg::REQ_FREE, 32'd16);
        add_req(bbpa_pkg::REQ_FREE, 32'd16);
        add_req(bbpa_pkg::REQ_ALLOC, 32'd0);
        add_req(bbpa_pkg::REQ_FREE, 32'hFFFF_FFFF);
        add_req(REQ_UNKNOWN, 32'hA5A5_5A5A);
        add_req(bbpa_pkg::REQ_QUERY, 32'hFFFF_FFFF);
        // wrapping pool, full pool, frees below base and past the end
        add_settle();
        add_write(bbpa_pkg::CFG_POOL_BASE, 32'hFFFF_FFF0);
        add_write(bbpa_pkg::CFG_BLOCK_SIZE, 32'hFFFF_FFFF);
        add_write(bbpa_pkg::CFG_BLOCK_COUNT, 32'hFFFF_F803);
        for (int i = 0; i < 4; i++) add_req(bbpa_pkg::REQ_ALLOC, 32'd0);
        add_req(bbpa_pkg::REQ_FREE, 32'hFFFF_FFEF);
        add_req(bbpa_pkg::REQ_FREE, 32'hFFFF_FFF0 + 32'd65535 * 32'd3);
        add_req(bbpa_pkg::REQ_QUERY, 32'hFFFF_FFF0 + 32'd65535 * 32'd2);
        // no blocks at all
        add_settle();
        add_write(bbpa_pkg::CFG_BLOCK_COUNT, 32'd0);
        add_req(bbpa_pkg::REQ_ALLOC, 32'd0);
        add_req(bbpa_pkg::REQ_FREE, 32'hFFFF_FFF0);
        add_req(bbpa_pkg::REQ_QUERY, 32'hFFFF_FFF0);
        // zero stride, then count above the maximum
        add_settle();
        add_write(bbpa_pkg::CFG_BLOCK_SIZE, 32'h0001_0000);
        add_write(bbpa_pkg::CFG_BLOCK_COUNT, 32'd2047);
        add_req(bbpa_pkg::REQ_FREE, 32'hFFFF_FFF5);
        add_req(bbpa_pkg::REQ_QUERY, 32'hFFFF_FFF0);
        add_req(bbpa_pkg::REQ_ALLOC, 32'd0);

        for (int ph = 0; ph < 8; ph++) begin
            add_settle();
            roll = $urandom_range(0, 9);
            add_write(bbpa_pkg::CFG_POOL_BASE, roll == 0 ? 32'hFFFF_FFFF :
                                     roll == 1 ? 32'd0 : $urandom);
            roll = $urandom_range(0, 9);
            add_write(bbpa_pkg::CFG_BLOCK_SIZE, ($urandom & 32'hFFFF_0000) |
                      (roll == 0 ? 32'd65535 : roll == 1 ? 32'd1 :
                       roll < 8 ? $urandom_range(1, 64) : $urandom_range(1, 65535)));
            roll = $urandom_range(0, 11);
            add_write(bbpa_pkg::CFG_BLOCK_COUNT, ($urandom & 32'hFFFF_F800) |
                      (roll == 0 ? 32'd1024 : roll == 1 ? 32'd1 : roll == 2 ? 32'd0 :
                       roll == 3 ? $urandom_range(1025, 2047) : $urandom_range(2, 40)));
            lim = gen_count > 1024 ? 1024 : gen_count;
            for (int j = 0; j < 80; j++) begin
                if (j == 40 && ph % 3 == 1) add_settle();
                roll = $urandom_range(0, 99);
                k = $urandom_range(0, lim + 1);
                a = block_addr_at(k);
                if (gen_size > 1 && $urandom_range(0, 3) == 0)
                    a = a + 32'($urandom_range(0, gen_size - 1));
                if ($urandom_range(0, 7) == 0) a = $urandom;
                if (roll < 40) add_req(bbpa_pkg::REQ_ALLOC, $urandom);
                else if (roll < 75) add_req(bbpa_pkg::REQ_FREE, a);
                else if (roll < 96)
                    add_req(bbpa_pkg::REQ_QUERY, roll < 86 ? a : gen_base - 32'd1);
                else add_req(REQ_UNKNOWN, a);
            end
        end

        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pending_ops.size() == 0 && !req_ch.valid && expected_rsps.size() == 0) break;
        end
        repeat (80) @(posedge i_clk);
        $display("checked %0d responses over %0d register writes: %0d allocations, %0d misses",
                 n_checked, n_writes, n_alloc_ok, n_alloc_miss);
        $display("frees %0d good %0d refused; queries %0d inside %0d outside; %0d unknown",
                 n_free_ok, n_free_bad, n_query_in, n_query_out, n_other);
        if (expected_rsps.size() != 0) begin
            $error("%0d responses never arrived", expected_rsps.size());
            errors++;
        end
        if (errors == 0) begin
            $display("bitmap_block_pool_allocator_tb: clean");
        end else begin
            $display("bitmap_block_pool_allocator_tb: errors");
        end
        $finish;
    end

    initial begin
        #(12 * 2_000_000);
        $display("bitmap_block_pool_allocator_tb: errors");
        $finish;
    end

endmodule
